>>> design/psqt_pkg.sv
// Shared constants and types for the polyphase sinc quadratic tap generator.
package psqt_pkg;

   // Sample store geometry
   localparam int TABLE_DEPTH     = 1024;
   localparam int ADDR_W          = $clog2(TABLE_DEPTH);
   localparam int MAX_HALF_LENGTH = 32;
   localparam int PHASE_COUNT_MAX = 512;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int PHASE_W  = 16;
   localparam int HL_W     = 6;
   localparam int NP_W     = 10;
   localparam int TAP_W    = 6;
   localparam int HLEN_W   = HL_W + NP_W;
   localparam int PROD_W   = PHASE_W + NP_W;

   // Request tdata layout (lowest bit first)
   localparam int ENTRY_INDEX_LSB = 0;
   localparam int ENTRY_VALUE_LSB = ENTRY_INDEX_LSB + ADDR_W;
   localparam int PHASE_LSB       = ENTRY_VALUE_LSB + SAMPLE_W;
   localparam int REQ_BITS        = PHASE_LSB + PHASE_W;
   localparam int REQ_TDATA_W     = ((REQ_BITS + 7) / 8) * 8;

   // Response tdata layout (lowest bit first)
   localparam int TAP_INDEX_LSB   = 0;
   localparam int COEFF_LSB       = TAP_INDEX_LSB + TAP_W;
   localparam int RSP_BITS        = COEFF_LSB + SAMPLE_W;
   localparam int RSP_TDATA_W     = ((RSP_BITS + 7) / 8) * 8;

   // Register indexes of the control port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_HALF_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PHASE_COUNT = 1'b1;
   localparam logic [HL_W-1:0] HALF_LENGTH_RESET = 6'd8;
   localparam logic [NP_W-1:0] PHASE_COUNT_RESET = 10'd32;

   // Request kinds
   localparam logic REQ_WRITE   = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

>>> design/polyphase_sinc_quadratic_taps_top.sv
// Polyphase windowed-sinc tap generator with quadratic interpolation over a sample store.
// Sequencing: a write transfer is stored directly in the sample store; a compute transfer passes
//   through setup and the size check, then each tap takes five reads through the single store read
//   port, then the six steps LAST, AB, MUL1, SUM, MUL2 and OUT, where OUT waits for the response
//   register. No new request is accepted until the last tap or the error response is loaded.
// Reset: half_length = 8, phase_count = 32, sequencer and output idle; store is not cleared.
module polyphase_sinc_quadratic_taps_top (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_index, entry_value, phase (lowest bit first)
   input  logic [psqt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  logic                               req_tuser,
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tap_index, coefficient (lowest bit first)
   output logic [psqt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // error
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   // control register writes
   input  logic                               csr_we,
   input  logic [psqt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psqt_pkg::NP_W-1:0]          csr_wdata
);
   import psqt_pkg::*;

   localparam int K_W   = ADDR_W + 1;      // base index, holds up to TABLE_DEPTH
   localparam int IDX_W = K_W + 1;         // signed neighbor index
   localparam int AB_W  = SAMPLE_W + 6;
   localparam int FX_W  = PHASE_W + 1;
   localparam int FA_W  = FX_W + AB_W;
   localparam int T_W   = FA_W + 1;
   localparam int S_W   = FX_W + T_W;
   localparam int R_W   = S_W - 35;
   localparam logic signed [S_W-1:0] ROUND_HALF = S_W'(1) << 34;
   localparam logic signed [R_W-1:0] SAT_MAX = R_W'(32767);
   localparam logic signed [R_W-1:0] SAT_MIN = -R_W'(32768);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SETUP = 4'd1;
   localparam logic [3:0] ST_INIT  = 4'd2;
   localparam logic [3:0] ST_READ  = 4'd3;
   localparam logic [3:0] ST_LAST  = 4'd4;
   localparam logic [3:0] ST_AB    = 4'd5;
   localparam logic [3:0] ST_MUL1  = 4'd6;
   localparam logic [3:0] ST_SUM   = 4'd7;
   localparam logic [3:0] ST_MUL2  = 4'd8;
   localparam logic [3:0] ST_OUT   = 4'd9;
   localparam logic [3:0] ST_ERR   = 4'd10;

   // configuration registers
   logic [HL_W-1:0] hl_ff;
   logic [NP_W-1:0] np_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hl_ff <= HALF_LENGTH_RESET;
         np_ff <= PHASE_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_HALF_LENGTH: hl_ff <= csr_wdata[HL_W-1:0];
            REG_PHASE_COUNT: np_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request fields
   logic [ADDR_W-1:0]  entry_index;
   sample_type         entry_value;
   logic [PHASE_W-1:0] phase;
   logic               req_xfer;

   assign entry_index = req_tdata[ENTRY_INDEX_LSB +: ADDR_W];
   assign entry_value = req_tdata[ENTRY_VALUE_LSB +: SAMPLE_W];
   assign phase       = req_tdata[PHASE_LSB +: PHASE_W];
   assign req_xfer    = req_tvalid && req_tready;

   // control state
   logic [3:0]         state_ff, state_in;
   logic [PHASE_W-1:0] ph_ff, ph_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [HLEN_W-1:0]  hlen_ff, hlen_in;
   logic               bad_ff, bad_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [TAP_W-1:0]   tap_ff, tap_in;
   logic [2:0]         rd_cnt_ff, rd_cnt_in;
   logic               rd_vld_ff;
   logic [2:0]         rd_sel_ff;
   logic               rd_zero_ff;

   logic [ADDR_W-1:0]  p_w;
   logic [PHASE_W-1:0] f_w;
   logic               right_w;
   logic               tap_last_w;
   logic               out_free;
   logic               out_load;

   assign p_w        = prod_ff[PROD_W-1:PHASE_W];
   assign f_w        = prod_ff[PHASE_W-1:0];
   assign right_w    = tap_ff >= hl_ff;
   assign tap_last_w = tap_ff == TAP_W'({hl_ff, 1'b0} - (HL_W + 1)'(1));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign out_load   = ((state_ff == ST_OUT) || (state_ff == ST_ERR)) && out_free;
   assign req_tready = state_ff == ST_IDLE;

   // size check and phase split
   always_comb begin
      hlen_in = HLEN_W'(hl_ff) * HLEN_W'(np_ff);
      bad_in  = (hl_ff < HL_W'(2)) || (hl_ff > HL_W'(MAX_HALF_LENGTH)) ||
                (np_ff == '0) || (np_ff > NP_W'(PHASE_COUNT_MAX)) ||
                (hlen_in > HLEN_W'(TABLE_DEPTH));
      prod_in = PROD_W'(ph_ff) * PROD_W'(np_ff);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      ph_in     = ph_ff;
      k_in      = k_ff;
      tap_in    = tap_ff;
      rd_cnt_in = rd_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_tuser == REQ_COMPUTE)) begin
               ph_in    = phase;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: state_in = ST_INIT;
         ST_INIT: begin
            if (bad_ff) begin
               state_in = ST_ERR;
            end else begin
               // leftmost tap sits (half_length-1) spacings above the offset
               k_in      = K_W'(p_w) + hlen_ff[K_W-1:0] - K_W'(np_ff);
               tap_in    = '0;
               rd_cnt_in = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == 3'd4) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: state_in = ST_AB;
         ST_AB:   state_in = ST_MUL1;
         ST_MUL1: state_in = ST_SUM;
         ST_SUM:  state_in = ST_MUL2;
         ST_MUL2: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               if (tap_last_w) begin
                  state_in = ST_IDLE;
               end else begin
                  tap_in    = tap_ff + TAP_W'(1);
                  rd_cnt_in = '0;
                  state_in  = ST_READ;
                  // left taps step down, right taps start just past the centre and step up
                  if (tap_in < hl_ff) begin
                     k_in = k_ff - K_W'(np_ff);
                  end else if (tap_in == hl_ff) begin
                     k_in = K_W'(np_ff) - K_W'(p_w);
                  end else begin
                     k_in = k_ff + K_W'(np_ff);
                  end
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= state_ff == ST_READ;
      end
      ph_ff     <= ph_in;
      k_ff      <= k_in;
      tap_ff    <= tap_in;
      rd_cnt_ff <= rd_cnt_in;
      if (state_ff == ST_SETUP) begin
         prod_ff <= prod_in;
         hlen_ff <= hlen_in;
         bad_ff  <= bad_in;
      end
   end

   // neighbor index: mirror below zero, zero at or beyond hlen
   logic signed [IDX_W-1:0] idx_w;
   logic [IDX_W-1:0]        mag_w;
   logic                    zero_w;
   logic [ADDR_W-1:0]       rd_addr;

   assign idx_w   = $signed({1'b0, k_ff}) + $signed(IDX_W'(rd_cnt_ff)) - IDX_W'(2);
   assign mag_w   = idx_w[IDX_W-1] ? IDX_W'(-idx_w) : IDX_W'(idx_w);
   assign zero_w  = HLEN_W'(mag_w) >= hlen_ff;
   assign rd_addr = mag_w[ADDR_W-1:0];

   // sample store
   sample_type sample_mem [TABLE_DEPTH];
   sample_type mem_q_ff;

   always_ff @(posedge clock) begin
      if (req_xfer && (req_tuser == REQ_WRITE)) begin
         sample_mem[entry_index] <= entry_value;
      end
      mem_q_ff <= sample_mem[rd_addr];
   end

   // five-sample window, c(k-2) .. c(k+2)
   sample_type win_ff [5];

   always_ff @(posedge clock) begin
      rd_sel_ff  <= rd_cnt_ff;
      rd_zero_ff <= zero_w;
      if (rd_vld_ff && (rd_sel_ff < 3'd5)) begin
         win_ff[rd_sel_ff] <= rd_zero_ff ? sample_type'(0) : mem_q_ff;
      end
   end

   // quadratic terms
   logic signed [AB_W-1:0] m2_w, m1_w, c0_w, p1_w, p2_w;
   logic signed [AB_W-1:0] a_in, b_raw, b_in;
   logic signed [AB_W-1:0] a_ff, b_ff, b2_ff;
   sample_type             c0_ff, c0_2_ff, c0_3_ff;

   assign m2_w  = AB_W'(win_ff[0]);
   assign m1_w  = AB_W'(win_ff[1]);
   assign c0_w  = AB_W'(win_ff[2]);
   assign p1_w  = AB_W'(win_ff[3]);
   assign p2_w  = AB_W'(win_ff[4]);
   assign a_in  = AB_W'(8) * (p1_w + m1_w) - AB_W'(14) * c0_w - p2_w - m2_w;
   assign b_raw = AB_W'(10) * (p1_w - m1_w) - p2_w + m2_w;
   assign b_in  = right_w ? -b_raw : b_raw;

   // f*(f*a + b*2^15) + c*2^35, then round half up, take the Q1.15 step and saturate to 16 bits
   logic signed [FX_W-1:0] fx_w;
   logic signed [FA_W-1:0] fa_in, fa_ff;
   logic signed [T_W-1:0]  t_in, t_ff;
   logic signed [S_W-1:0]  s_in, s_ff;
   logic signed [R_W-1:0]  r_w;
   sample_type             coef_w;

   assign fx_w  = $signed({1'b0, f_w});
   assign fa_in = FA_W'(fx_w) * FA_W'(a_ff);
   assign t_in  = T_W'(fa_ff) + (T_W'(b2_ff) <<< 15);
   assign s_in  = S_W'(fx_w) * S_W'(t_ff) + (S_W'(c0_3_ff) <<< 35) + ROUND_HALF;
   assign r_w   = s_ff[S_W-1:35];

   always_comb begin
      if (r_w > SAT_MAX) begin
         coef_w = sample_type'(SAT_MAX);
      end else if (r_w < SAT_MIN) begin
         coef_w = sample_type'(SAT_MIN);
      end else begin
         coef_w = r_w[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_AB) begin
         a_ff  <= a_in;
         b_ff  <= b_in;
         c0_ff <= win_ff[2];
      end
      if (state_ff == ST_MUL1) begin
         fa_ff   <= fa_in;
         b2_ff   <= b_ff;
         c0_2_ff <= c0_ff;
      end
      if (state_ff == ST_SUM) begin
         t_ff    <= t_in;
         c0_3_ff <= c0_2_ff;
      end
      if (state_ff == ST_MUL2) begin
         s_ff <= s_in;
      end
   end

   // response register
   logic             rsp_valid_ff;
   logic [TAP_W-1:0] rsp_tap_ff;
   sample_type       rsp_coef_ff;
   logic             rsp_err_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         if (state_ff == ST_ERR) begin
            rsp_tap_ff  <= '0;
            rsp_coef_ff <= '0;
            rsp_err_ff  <= 1'b1;
            rsp_last_ff <= 1'b1;
         end else begin
            rsp_tap_ff  <= tap_ff;
            rsp_coef_ff <= coef_w;
            rsp_err_ff  <= 1'b0;
            rsp_last_ff <= tap_last_w;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_coef_ff, rsp_tap_ff});
   assign rsp_tuser  = rsp_err_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("error transfer without tlast");

   a_read_in_read_state: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_READ))
      else $error("store read data without a read");

   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (7'(tap_ff) < {hl_ff, 1'b0}))
      else $error("tap counter beyond filter length");

   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      out_load && (state_ff == ST_OUT) && tap_last_w |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after last tap");

endmodule
